/* design/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

  localparam int NUM_ORDERS_DEF      = 4;
  localparam int SLOTS_PER_ORDER_DEF = 8;

  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 17;
  localparam int ORDER_W  = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'd200;
  localparam logic [PAGE_W-1:0] PAGE_UNIT_RST = 17'd100;

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_REINIT   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_UNIT = 1'b1;

  typedef struct packed {
    logic                load;
    logic                reinit;
    logic                rd;
    logic                put_up;
    logic                put_lo;
    logic                fin_ok;
    logic                fin_err;
    logic [STATUS_W-1:0] err_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_reinit;
    logic bad_order;
    logic found;
    logic need_split;
  } dp_status_t;

endpackage

/* design/bba_ctrl.sv */
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bba_pkg::dp_status_t stat,
  output bba_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UP,
    S_LO,
    S_TAKE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (stat.is_reinit) begin
            cmd.reinit = 1'b1;
          end else if (stat.bad_order) begin
            cmd.fin_err  = 1'b1;
            cmd.err_code = bba_pkg::ST_BAD_ORDER;
          end else if (!stat.found) begin
            cmd.fin_err  = 1'b1;
            cmd.err_code = bba_pkg::ST_NO_SPACE;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = stat.need_split ? S_UP : S_TAKE;
      end
      S_UP: begin
        cmd.put_up = 1'b1;
        state_nxt  = S_LO;
      end
      S_LO: begin
        cmd.put_lo = 1'b1;
        state_nxt  = S_RD;
      end
      S_TAKE: begin
        cmd.fin_ok = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* design/bba_dp.sv */
`timescale 1ns / 1ps

module bba_dp #(
  parameter int NUM_ORDERS      = bba_pkg::NUM_ORDERS_DEF,
  parameter int SLOTS_PER_ORDER = bba_pkg::SLOTS_PER_ORDER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]        cfg_wdata,
  input  logic                              in_operation,
  input  logic [bba_pkg::ORDER_W-1:0]       in_requested_order,
  input  bba_pkg::ctrl_cmd_t                cmd,
  output bba_pkg::dp_status_t               stat,
  output logic                              out_valid,
  output logic [bba_pkg::ADDR_W-1:0]        out_block_address,
  output logic [bba_pkg::STATUS_W-1:0]      out_status
);

  localparam int LVL_W  = $clog2(NUM_ORDERS);
  localparam int SLOT_W = $clog2(SLOTS_PER_ORDER);
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(NUM_ORDERS - 1);
  localparam logic [NUM_ORDERS-1:0][SLOTS_PER_ORDER-1:0] FILLED_RST =
    (NUM_ORDERS * SLOTS_PER_ORDER)'(1) << ((NUM_ORDERS - 1) * SLOTS_PER_ORDER);

  logic [bba_pkg::ADDR_W-1:0] mem [NUM_ORDERS][SLOTS_PER_ORDER];

  logic [NUM_ORDERS-1:0][SLOTS_PER_ORDER-1:0] filled_r, filled_nxt;
  logic                              top0_written_r;
  logic [bba_pkg::ADDR_W-1:0]        heap_base_r;
  logic [bba_pkg::PAGE_W-1:0]        page_unit_r;
  logic [LVL_W-1:0]                  level_r, order_r;
  logic [bba_pkg::ADDR_W-1:0]        rdata_r;
  logic                              out_valid_r;
  logic [bba_pkg::ADDR_W-1:0]        out_addr_r;
  logic [bba_pkg::STATUS_W-1:0]      out_status_r;

  logic [LVL_W-1:0]                  lvl_dn, chosen;
  logic                              any_found;
  logic [SLOT_W-1:0]                 ff_idx, fe_idx;
  logic                              fe_any;
  logic [bba_pkg::ADDR_W-1:0]        half, put_val;
  logic                              put_go, mem_we;
  logic [LVL_W-1:0]                  w_lvl;
  logic [SLOT_W-1:0]                 w_idx;
  logic [bba_pkg::ADDR_W-1:0]        w_data;

  assign lvl_dn = level_r - LVL_W'(1);

  // smallest level at or above the requested order that holds a block
  always_comb begin
    chosen    = '0;
    any_found = 1'b0;
    for (int l = NUM_ORDERS - 1; l >= 0; l--) begin
      if ((l >= int'(in_requested_order)) && (|filled_r[l])) begin
        chosen    = LVL_W'(l);
        any_found = 1'b1;
      end
    end
  end

  always_comb begin
    ff_idx = '0;
    for (int i = SLOTS_PER_ORDER - 1; i >= 0; i--) begin
      if (filled_r[level_r][i]) begin
        ff_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    fe_idx = '0;
    fe_any = 1'b0;
    for (int i = SLOTS_PER_ORDER - 1; i >= 0; i--) begin
      if (!filled_r[lvl_dn][i]) begin
        fe_idx = SLOT_W'(i);
        fe_any = 1'b1;
      end
    end
  end

  assign stat.is_reinit  = (in_operation == bba_pkg::OP_REINIT);
  assign stat.bad_order  = ({1'b0, in_requested_order} >= (bba_pkg::ORDER_W + 1)'(NUM_ORDERS));
  assign stat.found      = any_found;
  assign stat.need_split = (level_r != order_r);

  assign half    = bba_pkg::ADDR_W'(page_unit_r) << lvl_dn;
  assign put_val = cmd.put_up ? (rdata_r + half) : rdata_r;
  assign put_go  = (cmd.put_up || cmd.put_lo) && fe_any && (put_val != '0);

  always_comb begin
    filled_nxt = filled_r;
    if (cmd.reinit) begin
      filled_nxt = '0;
      filled_nxt[TOP_LVL][0] = (heap_base_r != '0);
    end
    if (cmd.rd) begin
      filled_nxt[level_r][ff_idx] = 1'b0;
    end
    if (put_go) begin
      filled_nxt[lvl_dn][fe_idx] = 1'b1;
    end
  end

  always_comb begin
    mem_we = cmd.reinit || put_go;
    if (cmd.reinit) begin
      w_lvl  = TOP_LVL;
      w_idx  = '0;
      w_data = heap_base_r;
    end else begin
      w_lvl  = lvl_dn;
      w_idx  = fe_idx;
      w_data = put_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[w_lvl][w_idx] <= w_data;
    end
    if (cmd.rd) begin
      if ((level_r == TOP_LVL) && (ff_idx == '0) && !top0_written_r) begin
        rdata_r <= bba_pkg::HEAP_BASE_RST;
      end else begin
        rdata_r <= mem[level_r][ff_idx];
      end
    end
    if (cmd.load) begin
      level_r <= chosen;
      order_r <= LVL_W'(in_requested_order);
    end else if (cmd.put_lo) begin
      level_r <= lvl_dn;
    end
    if (cmd.fin_ok) begin
      out_addr_r   <= rdata_r;
      out_status_r <= bba_pkg::ST_OK;
    end else if (cmd.fin_err) begin
      out_addr_r   <= '0;
      out_status_r <= cmd.err_code;
    end else if (cmd.reinit) begin
      out_addr_r   <= '0;
      out_status_r <= bba_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r       <= FILLED_RST;
      top0_written_r <= 1'b0;
      heap_base_r    <= bba_pkg::HEAP_BASE_RST;
      page_unit_r    <= bba_pkg::PAGE_UNIT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      filled_r    <= filled_nxt;
      out_valid_r <= cmd.fin_ok || cmd.fin_err || cmd.reinit;
      if (cmd.reinit) begin
        top0_written_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::CFG_HEAP_BASE: heap_base_r <= cfg_wdata;
          bba_pkg::CFG_PAGE_UNIT: page_unit_r <= cfg_wdata[bba_pkg::PAGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

  a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bba_pkg::ST_OK)) |-> (out_block_address == '0))
    else $error("error result carries an address");

  a_rd_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (level_r >= order_r))
    else $error("split walked below requested order");

  a_split_above: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_up || cmd.put_lo) |-> (level_r != order_r))
    else $error("split at requested order");

  a_reinit_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reinit |=> ($countones(filled_r) <= 1))
    else $error("reinit left more than one block");

endmodule

/* design/buddy_block_allocator.sv */
`timescale 1ns / 1ps
// reinit, bad order and no space give their result in the cycle after acceptance
// an allocation steps through S_RD, then S_UP, S_LO and S_RD again per split, then S_TAKE
// throughput: one transaction at a time; for an allocation, busy drops in the cycle the result is shown
// each split costs one registered slot-memory read and at most two writes on its single write port
// results are strobed for one cycle; the receiver cannot stall
// reset (synchronous, active low): top level holds one block at 200, page unit 100

module buddy_block_allocator #(
  parameter int NUM_ORDERS      = bba_pkg::NUM_ORDERS_DEF,
  parameter int SLOTS_PER_ORDER = bba_pkg::SLOTS_PER_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [bba_pkg::ORDER_W-1:0]   in_requested_order,
  output logic                          out_valid,
  output logic [bba_pkg::ADDR_W-1:0]    out_block_address,
  output logic [bba_pkg::STATUS_W-1:0]  out_status
);

  bba_pkg::ctrl_cmd_t  cmd;
  bba_pkg::dp_status_t stat;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bba_dp #(
    .NUM_ORDERS      (NUM_ORDERS),
    .SLOTS_PER_ORDER (SLOTS_PER_ORDER)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_requested_order (in_requested_order),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_block_address  (out_block_address),
    .out_status         (out_status)
  );

endmodule
